@@ design/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ design/rvdec_pkg.sv @@
package rvdec_pkg;

	typedef enum logic [5:0] {
		OP_ILLEGAL = 6'd0,
		OP_LUI     = 6'd1,
		OP_AUIPC   = 6'd2,
		OP_JAL     = 6'd3,
		OP_JALR    = 6'd4,
		OP_BEQ     = 6'd5,
		OP_BNE     = 6'd6,
		OP_BLT     = 6'd7,
		OP_BGE     = 6'd8,
		OP_BLTU    = 6'd9,
		OP_BGEU    = 6'd10,
		OP_LB      = 6'd11,
		OP_LH      = 6'd12,
		OP_LW      = 6'd13,
		OP_LBU     = 6'd14,
		OP_LHU     = 6'd15,
		OP_SB      = 6'd16,
		OP_SH      = 6'd17,
		OP_SW      = 6'd18,
		OP_ADDI    = 6'd19,
		OP_SLTI    = 6'd20,
		OP_SLTIU   = 6'd21,
		OP_XORI    = 6'd22,
		OP_ORI     = 6'd23,
		OP_ANDI    = 6'd24,
		OP_SLLI    = 6'd25,
		OP_SRLI    = 6'd26,
		OP_SRAI    = 6'd27,
		OP_ADD     = 6'd28,
		OP_SUB     = 6'd29,
		OP_SLL     = 6'd30,
		OP_SLT     = 6'd31,
		OP_SLTU    = 6'd32,
		OP_XOR     = 6'd33,
		OP_SRL     = 6'd34,
		OP_SRA     = 6'd35,
		OP_OR      = 6'd36,
		OP_AND     = 6'd37,
		OP_FENCE   = 6'd38,
		OP_FENCE_I = 6'd39,
		OP_ECALL   = 6'd40,
		OP_EBREAK  = 6'd41,
		OP_CSRRW   = 6'd42,
		OP_CSRRS   = 6'd43,
		OP_CSRRC   = 6'd44,
		OP_CSRRWI  = 6'd45,
		OP_CSRRSI  = 6'd46,
		OP_CSRRCI  = 6'd47,
		OP_LWU     = 6'd48,
		OP_LD      = 6'd49,
		OP_SD      = 6'd50,
		OP_ADDIW   = 6'd51,
		OP_SLLIW   = 6'd52,
		OP_SRLIW   = 6'd53,
		OP_SRAIW   = 6'd54,
		OP_ADDW    = 6'd55,
		OP_SUBW    = 6'd56,
		OP_SLLW    = 6'd57,
		OP_SRLW    = 6'd58,
		OP_SRAW    = 6'd59,
		OP_SRET    = 6'd60,
		OP_MRET    = 6'd61
	} op_t;

	typedef enum logic [2:0] {
		FMT_R = 3'd0,
		FMT_I = 3'd1,
		FMT_S = 3'd2,
		FMT_B = 3'd3,
		FMT_U = 3'd4,
		FMT_J = 3'd5
	} fmt_t;

	typedef struct packed {
		op_t  op;
		fmt_t fmt;
	} dec_t;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP32   = 7'h3B;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [5:0] F6_BASE = 6'h00;
	localparam logic [5:0] F6_ALT  = 6'h10;

	localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
	localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
	localparam logic [31:0] WORD_SRET   = 32'h1020_0073;
	localparam logic [31:0] WORD_MRET   = 32'h3020_0073;
	localparam logic [31:0] FENCE_MASK  = 32'hF00F_FFF0;
	localparam logic [31:0] FENCEI_MASK = 32'hFFFF_EFF0;

endpackage

@@ design/rvdec_opdec.sv @@
module rvdec_opdec import rvdec_pkg::*; (
	input  logic [31:0] word,
	output dec_t        dec
);

	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [5:0] f6;
	op_t        op;
	fmt_t       fmt;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign f7  = word[31:25];
	assign f6  = word[31:26];

	always_comb begin
		op  = OP_ILLEGAL;
		fmt = FMT_R;
		unique case (opc)
			OPC_LUI: begin
				op  = OP_LUI;
				fmt = FMT_U;
			end
			OPC_AUIPC: begin
				op  = OP_AUIPC;
				fmt = FMT_U;
			end
			OPC_JAL: begin
				op  = OP_JAL;
				fmt = FMT_J;
			end
			OPC_JALR: begin
				fmt = FMT_I;
				if (f3 == 3'd0) op = OP_JALR;
			end
			OPC_BRANCH: begin
				fmt = FMT_B;
				unique case (f3)
					3'd0: op = OP_BEQ;
					3'd1: op = OP_BNE;
					3'd4: op = OP_BLT;
					3'd5: op = OP_BGE;
					3'd6: op = OP_BLTU;
					3'd7: op = OP_BGEU;
					default: op = OP_ILLEGAL;
				endcase
			end
			OPC_LOAD: begin
				fmt = FMT_I;
				unique case (f3)
					3'd0: op = OP_LB;
					3'd1: op = OP_LH;
					3'd2: op = OP_LW;
					3'd3: op = OP_LD;
					3'd4: op = OP_LBU;
					3'd5: op = OP_LHU;
					3'd6: op = OP_LWU;
					default: op = OP_ILLEGAL;
				endcase
			end
			OPC_STORE: begin
				fmt = FMT_S;
				unique case (f3)
					3'd0: op = OP_SB;
					3'd1: op = OP_SH;
					3'd2: op = OP_SW;
					3'd3: op = OP_SD;
					default: op = OP_ILLEGAL;
				endcase
			end
			OPC_OPIMM: begin
				fmt = FMT_I;
				unique case (f3)
					3'd0: op = OP_ADDI;
					3'd1: op = (f6 == F6_BASE) ? OP_SLLI : OP_ILLEGAL;
					3'd2: op = OP_SLTI;
					3'd3: op = OP_SLTIU;
					3'd4: op = OP_XORI;
					3'd5: begin
						if (f6 == F6_BASE) op = OP_SRLI;
						else if (f6 == F6_ALT) op = OP_SRAI;
					end
					3'd6: op = OP_ORI;
					3'd7: op = OP_ANDI;
					default: op = OP_ILLEGAL;
				endcase
			end
			OPC_OPIMM32: begin
				fmt = FMT_I;
				unique case (f3)
					3'd0: op = OP_ADDIW;
					3'd1: op = (f7 == F7_BASE) ? OP_SLLIW : OP_ILLEGAL;
					3'd5: begin
						if (f7 == F7_BASE) op = OP_SRLIW;
						else if (f7 == F7_ALT) op = OP_SRAIW;
					end
					default: op = OP_ILLEGAL;
				endcase
			end
			OPC_OP: begin
				if (f7 == F7_BASE) begin
					unique case (f3)
						3'd0: op = OP_ADD;
						3'd1: op = OP_SLL;
						3'd2: op = OP_SLT;
						3'd3: op = OP_SLTU;
						3'd4: op = OP_XOR;
						3'd5: op = OP_SRL;
						3'd6: op = OP_OR;
						3'd7: op = OP_AND;
						default: op = OP_ILLEGAL;
					endcase
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) op = OP_SUB;
					else if (f3 == 3'd5) op = OP_SRA;
				end
			end
			OPC_OP32: begin
				if (f7 == F7_BASE) begin
					if (f3 == 3'd0) op = OP_ADDW;
					else if (f3 == 3'd1) op = OP_SLLW;
					else if (f3 == 3'd5) op = OP_SRLW;
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) op = OP_SUBW;
					else if (f3 == 3'd5) op = OP_SRAW;
				end
			end
			OPC_FENCE: begin
				fmt = FMT_I;
				if (f3 == 3'd0 && (word & FENCE_MASK) == 32'd0) op = OP_FENCE;
				else if (f3 == 3'd1 && (word & FENCEI_MASK) == 32'd0) op = OP_FENCE_I;
			end
			OPC_SYSTEM: begin
				fmt = FMT_I;
				unique case (f3)
					3'd0: begin
						if (word == WORD_ECALL) op = OP_ECALL;
						else if (word == WORD_EBREAK) op = OP_EBREAK;
						else if (word == WORD_SRET) op = OP_SRET;
						else if (word == WORD_MRET) op = OP_MRET;
					end
					3'd1: op = OP_CSRRW;
					3'd2: op = OP_CSRRS;
					3'd3: op = OP_CSRRC;
					3'd5: op = OP_CSRRWI;
					3'd6: op = OP_CSRRSI;
					3'd7: op = OP_CSRRCI;
					default: op = OP_ILLEGAL;
				endcase
			end
			default: op = OP_ILLEGAL;
		endcase
		if (op == OP_ILLEGAL) fmt = FMT_R;
	end

	assign dec.op  = op;
	assign dec.fmt = fmt;

endmodule

@@ design/rv64i_instruction_decoder_top.sv @@
// Channel | Signals                                   | Direction
// input   | in_valid, in_ready, instruction_word      | into block
// output  | out_valid, out_ready, operation_code,     | out of block
//         | immediate_format, immediate_value,        |
//         | dest_register, source_register_one/two,   |
//         | illegal_flag                              |
// Three register stages: word capture, opcode/format decode, immediate and output.
// One transaction per cycle unless stalled; out_valid rises when the word reaches stage 3.
// arst_n clears all valid bits; payload registers are not reset.
// A stall on the output freezes all stages together, so in_ready = !(out_valid & !out_ready).
`include "assert_macros.svh"

module rv64i_instruction_decoder_top import rvdec_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instruction_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         operation_code,
	output logic [2:0]         immediate_format,
	output logic signed [31:0] immediate_value,
	output logic [4:0]         dest_register,
	output logic [4:0]         source_register_one,
	output logic [4:0]         source_register_two,
	output logic               illegal_flag
);

	logic        stall;
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	logic [31:0] word_s2;
	dec_t        dec_s2;
	dec_t        dec_c;
	logic [31:0] imm_c;
	logic        valid_s3;
	op_t         op_s3;
	fmt_t        fmt_s3;
	logic [31:0] imm_s3;
	logic [4:0]  rd_s3;
	logic [4:0]  rs1_s3;
	logic [4:0]  rs2_s3;

	assign stall    = valid_s3 && !out_ready;
	assign in_ready = !stall;

	rvdec_opdec u_opdec (
		.word (word_s1),
		.dec  (dec_c)
	);

	always_comb begin
		unique case (dec_s2.fmt)
			FMT_I: imm_c = {{20{word_s2[31]}}, word_s2[31:20]};
			FMT_S: imm_c = {{20{word_s2[31]}}, word_s2[31:25], word_s2[11:7]};
			FMT_B: imm_c = {{20{word_s2[31]}}, word_s2[7], word_s2[30:25],
				word_s2[11:8], 1'b0};
			FMT_U: imm_c = {word_s2[31:12], 12'd0};
			FMT_J: imm_c = {{12{word_s2[31]}}, word_s2[19:12], word_s2[20],
				word_s2[30:21], 1'b0};
			default: imm_c = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			word_s1 <= instruction_word;
			word_s2 <= word_s1;
			dec_s2  <= dec_c;
			op_s3   <= dec_s2.op;
			fmt_s3  <= dec_s2.fmt;
			imm_s3  <= imm_c;
			rd_s3   <= word_s2[11:7];
			rs1_s3  <= word_s2[19:15];
			rs2_s3  <= word_s2[24:20];
		end
	end

	assign out_valid           = valid_s3;
	assign operation_code      = op_s3;
	assign immediate_format    = fmt_s3;
	assign immediate_value     = imm_s3;
	assign dest_register       = rd_s3;
	assign source_register_one = rs1_s3;
	assign source_register_two = rs2_s3;
	assign illegal_flag        = (op_s3 == OP_ILLEGAL);

	`ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_s1, "accepted transaction lost at stage 1")
	`ASSERT_NEXT(a_stall_holds_s2, stall, $stable(valid_s2) && $stable(word_s2), "stage 2 moved during stall")
	`ASSERT_IMPLIES(a_illegal_fmt, out_valid && illegal_flag, immediate_format == FMT_R && immediate_value == 32'sd0, "illegal result carries immediate")
	`ASSERT_IMPLIES(a_rformat_zero, out_valid && immediate_format == FMT_R, immediate_value == 32'sd0, "R format with nonzero immediate")

endmodule
